// File: hw/rtl/sld_pkg.sv
// Shared constants, codes and types of the sync/length/XOR deframer.
// Used by every module under hw/rtl; depends on nothing.
package sld_pkg;

   localparam int BUFFER_BYTES = 32;
   localparam int MAX_PAYLOAD  = BUFFER_BYTES - 4;
   localparam int ADDR_W       = $clog2(MAX_PAYLOAD);
   localparam int LEN_W        = $clog2(MAX_PAYLOAD + 1);

   localparam logic [7:0] SYNC_DATA    = 8'hA4;
   localparam logic [7:0] SYNC_COMMAND = 8'hF0;

   localparam logic [1:0] ST_PAYLOAD  = 2'd0;
   localparam logic [1:0] ST_EMPTY_OK = 2'd1;
   localparam logic [1:0] ST_BAD_SUM  = 2'd2;
   localparam logic [1:0] ST_TOO_LONG = 2'd3;

   // Frame outcome handed from the parser to the emitter.
   typedef struct packed {
      logic             valid;
      logic [1:0]       status;
      logic             is_command;
      logic [7:0]       device;
      logic [LEN_W-1:0] length;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   function automatic logic [4:0] to_index(input logic [ADDR_W-1:0] a);
      logic [31:0] t;
      t = 32'(a);
      return t[4:0];
   endfunction

endpackage

// File: hw/rtl/sld_ram.sv
// Payload buffer: one write port, one read port with registered data.
// Depends on sld_pkg.
module sld_ram (
   input  logic                      clock,
   input  sld_pkg::ram_wr_type       wr,
   input  logic                      rd_en,
   input  logic [sld_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                rd_data
);
   import sld_pkg::*;

   logic [7:0] mem [MAX_PAYLOAD];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/sld_parser.sv
// Frame parser: sync hunt, header, payload buffering and checksum check.
// Depends on sld_pkg; writes payload bytes into sld_ram.
module sld_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   output sld_pkg::job_type    job,
   output sld_pkg::ram_wr_type wr
);
   import sld_pkg::*;

   localparam logic [1:0] P_HUNT    = 2'd0;
   localparam logic [1:0] P_DEVICE  = 2'd1;
   localparam logic [1:0] P_LENGTH  = 2'd2;
   localparam logic [1:0] P_PAYLOAD = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             kind_ff, kind_in;
   logic [7:0]       device_ff, device_in;
   logic [7:0]       xor_ff, xor_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= P_HUNT;
         pos_ff    <= '0;
         length_ff <= '0;
         kind_ff   <= 1'b0;
         device_ff <= '0;
         xor_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         length_ff <= length_in;
         kind_ff   <= kind_in;
         device_ff <= device_in;
         xor_ff    <= xor_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      length_in  = length_ff;
      kind_in    = kind_ff;
      device_in  = device_ff;
      xor_in     = xor_ff;
      job.valid      = 1'b0;
      job.status     = ST_PAYLOAD;
      job.is_command = kind_ff;
      job.device     = device_ff;
      job.length     = length_ff;
      wr.en   = 1'b0;
      wr.addr = pos_ff[ADDR_W-1:0];
      wr.data = rx_byte;
      if (accept) begin
         case (state_ff)
            P_HUNT: begin
               if (rx_byte == SYNC_DATA || rx_byte == SYNC_COMMAND) begin
                  state_in  = P_DEVICE;
                  kind_in   = (rx_byte == SYNC_COMMAND);
                  pos_in    = '0;
                  length_in = '0;
                  xor_in    = '0;
               end
            end
            P_DEVICE: begin
               device_in = rx_byte;
               state_in  = P_LENGTH;
            end
            P_LENGTH: begin
               if (int'(rx_byte) > MAX_PAYLOAD) begin
                  job.valid  = 1'b1;
                  job.status = ST_TOO_LONG;
                  state_in   = P_HUNT;
               end else begin
                  length_in = LEN_W'(rx_byte);
                  pos_in    = '0;
                  xor_in    = '0;
                  state_in  = P_PAYLOAD;
               end
            end
            P_PAYLOAD: begin
               if (pos_ff < length_ff) begin
                  wr.en  = 1'b1;
                  xor_in = xor_ff ^ rx_byte;
                  pos_in = pos_ff + 1'b1;
               end else begin
                  // checksum byte
                  job.valid = 1'b1;
                  state_in  = P_HUNT;
                  if (xor_ff != rx_byte) begin
                     job.status = ST_BAD_SUM;
                  end else if (length_ff == '0) begin
                     job.status = ST_EMPTY_OK;
                  end else begin
                     job.status = ST_PAYLOAD;
                  end
               end
            end
            default: state_in = P_HUNT;
         endcase
      end
   end

endmodule

// File: hw/rtl/sld_emitter.sv
// Result sequencer: reads buffered payload back and presents result items.
// Depends on sld_pkg; reads sld_ram.
module sld_emitter (
   input  logic                       clock,
   input  logic                       reset,
   input  sld_pkg::job_type           job,
   output logic                       busy,
   output logic                       rd_en,
   output logic [sld_pkg::ADDR_W-1:0] rd_addr,
   input  logic [7:0]                 rd_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_is_command,
   output logic [7:0]                 rsp_device_type,
   output logic [7:0]                 rsp_payload_byte,
   output logic [4:0]                 rsp_byte_index,
   output logic                       rsp_last
);
   import sld_pkg::*;

   localparam logic [1:0] E_IDLE = 2'd0;
   localparam logic [1:0] E_READ = 2'd1;
   localparam logic [1:0] E_SHOW = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [1:0]        status_ff, status_in;
   logic              kind_ff, kind_in;
   logic [7:0]        device_ff, device_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic              is_payload;
   logic              last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      status_ff <= status_in;
      kind_ff   <= kind_in;
      device_ff <= device_in;
      length_ff <= length_in;
   end

   assign is_payload = (status_ff == ST_PAYLOAD);
   assign last = !is_payload || ((LEN_W'(idx_ff) + 1'b1) == length_ff);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      kind_in   = kind_ff;
      device_in = device_ff;
      length_in = length_ff;
      case (state_ff)
         E_IDLE: begin
            if (job.valid) begin
               status_in = job.status;
               kind_in   = job.is_command;
               device_in = job.device;
               length_in = job.length;
               idx_in    = '0;
               state_in  = (job.status == ST_PAYLOAD) ? E_READ : E_SHOW;
            end
         end
         E_READ: state_in = E_SHOW;
         E_SHOW: begin
            if (rsp_ready) begin
               if (last) begin
                  state_in = E_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = E_READ;
               end
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   assign busy    = (state_ff != E_IDLE);
   assign rd_en   = (state_ff == E_READ);
   assign rd_addr = idx_ff;

   assign rsp_valid        = (state_ff == E_SHOW);
   assign rsp_status       = status_ff;
   assign rsp_is_command   = kind_ff;
   assign rsp_device_type  = device_ff;
   assign rsp_payload_byte = is_payload ? rd_data : 8'd0;
   assign rsp_byte_index   = is_payload ? to_index(idx_ff) : 5'd0;
   assign rsp_last         = last;

endmodule

// File: hw/rtl/sync_length_xor_deframer.sv
// Top level of the sync/length/XOR deframer.
// Depends on sld_pkg, sld_ram, sld_parser and sld_emitter.
//
// Input channel req_*: one received serial byte per item. While hunting,
// only 0xA4 (data) or 0xF0 (command) opens a frame; other bytes are dropped.
// Frame: sync, device type, length, payload bytes, XOR checksum of payload.
// Result channel rsp_*: for a good frame one item per payload byte, the
// final one marked last; a good empty frame gives one "empty ok" item; a
// bad checksum or a length above the buffer gives one error item.
// Bytes are taken one per cycle while no results are pending. After the
// checksum (or bad length) byte until the last result is taken, req_ready
// is low. Error and empty-ok items appear in the cycle after that byte;
// each payload result is first read from the buffer, then presented, as
// the single-read-port payload buffer has registered read data.
// A stalled receiver holds the current result; nothing is lost.
// Reset returns the block to hunting; the payload buffer is not cleared.
module sync_length_xor_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic       rsp_is_command,
   output logic [7:0] rsp_device_type,
   output logic [7:0] rsp_payload_byte,
   output logic [4:0] rsp_byte_index,
   output logic       rsp_last
);
   import sld_pkg::*;

   job_type           job;
   ram_wr_type        wr;
   logic              busy;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   // Parser stalls while the emitter reads the buffer back or presents results.
   assign req_ready = !busy;

   sld_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_valid && req_ready),
      .rx_byte (req_rx_byte),
      .job     (job),
      .wr      (wr)
   );

   sld_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sld_emitter u_emitter (
      .clock            (clock),
      .reset            (reset),
      .job              (job),
      .busy             (busy),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_is_command   (rsp_is_command),
      .rsp_device_type  (rsp_device_type),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last         (rsp_last)
   );

   a_no_input_while_results: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while results pending");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_PAYLOAD |-> rsp_last)
      else $error("non-payload result not marked last");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_PAYLOAD |-> rsp_payload_byte == 8'd0
         && rsp_byte_index == 5'd0)
      else $error("error result carries payload fields");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("input not reopened after last result");

   a_no_ram_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr.en)
      else $error("payload write while buffer is read back");

endmodule
